// ===== design/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// shared types, constants and helper functions of the sv39 page table walker
// ----------------------------------------------------------------------------
package ptw_pkg;

   // default page-table memory depth in 64-bit words
   localparam int unsigned MEM_WORDS_DEF = 4096;

   // sv39 geometry
   localparam int unsigned VA_W      = 39;
   localparam int unsigned PA_W      = 56;
   localparam int unsigned PPN_W     = 44;
   localparam int unsigned PTE_W     = 64;
   localparam int unsigned PTE_SHIFT = 10;
   localparam int unsigned PG_SHIFT  = 12;
   localparam int unsigned LVL_BITS  = 9;
   localparam int unsigned ENT_ADDR_W = PPN_W + LVL_BITS;

   // csr port geometry
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 64;

   // register index, taken from byte address bit 3
   typedef enum logic {
      CSR_ROOT_PPN = 1'b0,
      CSR_UNUSED   = 1'b1
   } csr_idx_type;

   // item kinds
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_WALK  = 1'b1
   } req_kind_type;

   // walk result codes
   typedef enum logic [1:0] {
      FAULT_NONE    = 2'd0,
      FAULT_INVALID = 2'd1,
      FAULT_NO_LEAF = 2'd2,
      FAULT_RANGE   = 2'd3
   } fault_type;

   // walker control states, one-hot
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   // page tree levels
   localparam logic [1:0] LVL_TOP = 2'd2;
   localparam logic [1:0] LVL_MID = 2'd1;
   localparam logic [1:0] LVL_BOT = 2'd0;

   // vpn field of the virtual address for one level
   function automatic logic [LVL_BITS-1:0] vpn_sel(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
      logic [LVL_BITS-1:0] vpn;
      case (lvl)
         LVL_TOP: vpn = va[PG_SHIFT+2*LVL_BITS +: LVL_BITS];
         LVL_MID: vpn = va[PG_SHIFT+LVL_BITS +: LVL_BITS];
         default: vpn = va[PG_SHIFT +: LVL_BITS];
      endcase
      return vpn;
   endfunction

   // physical address of a leaf: pte ppn above the page offset of that level
   function automatic logic [PA_W-1:0] pa_build(input logic [PTE_W-1:0] pte,
                                                input logic [VA_W-1:0] va,
                                                input logic [1:0] lvl);
      logic [PA_W-1:0] base;
      logic [PA_W-1:0] vext;
      logic [PA_W-1:0] pmask;
      base = {pte[PTE_SHIFT +: PPN_W], {PG_SHIFT{1'b0}}};
      vext = PA_W'(va);
      case (lvl)
         LVL_TOP: pmask = (PA_W'(1) << (PG_SHIFT + 2*LVL_BITS)) - PA_W'(1);
         LVL_MID: pmask = (PA_W'(1) << (PG_SHIFT + LVL_BITS)) - PA_W'(1);
         default: pmask = (PA_W'(1) << PG_SHIFT) - PA_W'(1);
      endcase
      return (base & ~pmask) | (vext & pmask);
   endfunction

endpackage

// ===== design/ptw_mem.sv =====
// ----------------------------------------------------------------------------
// ptw_mem
// page-table word store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ptw_mem #(
   parameter int unsigned MEM_WORDS = ptw_pkg::MEM_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MEM_WORDS)-1:0]  wr_addr,
   input  logic [ptw_pkg::PTE_W-1:0]     wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MEM_WORDS)-1:0]  rd_addr,
   output logic [ptw_pkg::PTE_W-1:0]     rd_data
);

   logic [ptw_pkg::PTE_W-1:0] mem_ff [MEM_WORDS];
   logic [ptw_pkg::PTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ptw_csr.sv =====
// ----------------------------------------------------------------------------
// ptw_csr
// apb-style register port holding the root page number
// ----------------------------------------------------------------------------
module ptw_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [ptw_pkg::PPN_W-1:0]         root_ppn
);

   logic [ptw_pkg::PPN_W-1:0] root_ppn_ff;
   logic [ptw_pkg::PPN_W-1:0] root_ppn_in;
   logic                      csr_wr;
   ptw_pkg::csr_idx_type      reg_idx;

   // registers sit on 8-byte strides
   assign reg_idx = ptw_pkg::csr_idx_type'(paddr[3]);
   assign csr_wr  = psel & penable & pwrite;

   always_comb begin
      root_ppn_in = root_ppn_ff;
      prdata      = '0;
      unique case (reg_idx)
         ptw_pkg::CSR_ROOT_PPN: begin
            prdata = ptw_pkg::CSR_DATA_W'(root_ppn_ff);
            if (csr_wr) begin
               root_ppn_in = pwdata[ptw_pkg::PPN_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ppn_ff <= '0;
      end else begin
         root_ppn_ff <= root_ppn_in;
      end
   end

   assign pready   = 1'b1;
   assign root_ppn = root_ppn_ff;

endmodule

// ===== design/sv39_page_table_walker_unit.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_walker_unit
// three-level sv39 page table walk over an internal page-table memory
// ----------------------------------------------------------------------------
// After reset the block sweeps its page-table memory to zero, one word per
// cycle, so req_stall stays high until all MEM_WORDS words (4096 by
// default) are cleared; root_ppn can be written during that time. A write
// item stores one 64-bit word and gives no result; an index beyond the
// memory is dropped. A walk item issues the top-level entry read when it
// is taken, then evaluates one level per ST_WALK step; the walk is a chain
// of dependent reads through the registered memory read port (the next
// entry address comes from the entry just read). An entry address beyond
// the memory ends the walk with FAULT_RANGE in the cycle after it forms.
// Results sit in an output register, so the next item is taken while a
// finished result still waits on rsp_stall.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_unit #(
   parameter int unsigned MEM_WORDS = ptw_pkg::MEM_WORDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,

   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [ptw_pkg::VA_W-1:0]          req_vaddr,
   input  logic [11:0]                       req_word_index,
   input  logic [ptw_pkg::PTE_W-1:0]         req_word_data,

   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_walk_ok,
   output logic [1:0]                        rsp_fault_code,
   output logic [1:0]                        rsp_page_level,
   output logic [ptw_pkg::PTE_W-1:0]         rsp_leaf_entry,
   output logic [ptw_pkg::PA_W-1:0]          rsp_phys_addr,
   output logic [ptw_pkg::PTE_W-1:0]         rsp_entry_level2,
   output logic [ptw_pkg::PTE_W-1:0]         rsp_entry_level1,
   output logic [ptw_pkg::PTE_W-1:0]         rsp_entry_level0,
   output logic [2:0]                        rsp_level_valid_mask
);

   localparam int unsigned AW = $clog2(MEM_WORDS);
   localparam int unsigned EAW = ptw_pkg::ENT_ADDR_W;
   localparam logic [EAW-1:0] MemLimit = EAW'(MEM_WORDS);
   localparam logic [AW-1:0]  ClrLast  = AW'(MEM_WORDS - 1);

   // root page number from the register port
   logic [ptw_pkg::PPN_W-1:0] root_ppn;

   // memory port
   logic                      mem_wr_en;
   logic [AW-1:0]             mem_wr_addr;
   logic [ptw_pkg::PTE_W-1:0] mem_wr_data;
   logic                      mem_rd_en;
   logic [AW-1:0]             mem_rd_addr;
   logic [ptw_pkg::PTE_W-1:0] mem_rd_data;

   // control
   ptw_pkg::state_type        state_ff, state_in;
   logic [AW-1:0]             clr_cnt_ff, clr_cnt_in;

   // walk working state
   logic [1:0]                lvl_ff, lvl_in;
   logic [ptw_pkg::VA_W-1:0]  va_ff, va_in;
   logic                      oor_ff, oor_in;
   logic [ptw_pkg::PTE_W-1:0] ent2_ff, ent2_in;
   logic [ptw_pkg::PTE_W-1:0] ent1_ff, ent1_in;
   logic [ptw_pkg::PTE_W-1:0] ent0_ff, ent0_in;
   logic [2:0]                vmask_ff, vmask_in;
   logic                      ok_ff, ok_in;
   ptw_pkg::fault_type        fault_ff, fault_in;
   logic [1:0]                leaf_lvl_ff, leaf_lvl_in;
   logic [ptw_pkg::PTE_W-1:0] leaf_ff, leaf_in;
   logic [ptw_pkg::PA_W-1:0]  pa_ff, pa_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic                      out_ok_ff;
   ptw_pkg::fault_type        out_fault_ff;
   logic [1:0]                out_leaf_lvl_ff;
   logic [ptw_pkg::PTE_W-1:0] out_leaf_ff;
   logic [ptw_pkg::PA_W-1:0]  out_pa_ff;
   logic [ptw_pkg::PTE_W-1:0] out_ent2_ff;
   logic [ptw_pkg::PTE_W-1:0] out_ent1_ff;
   logic [ptw_pkg::PTE_W-1:0] out_ent0_ff;
   logic [2:0]                out_vmask_ff;

   logic                      out_free;
   logic                      load_out;
   logic                      walk_done;
   logic [EAW-1:0]            ent_addr;
   logic [EAW-1:0]            widx_ext;
   logic [ptw_pkg::PTE_W-1:0] pte;
   logic [1:0]                lvl_next;

   ptw_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .root_ppn (root_ppn)
   );

   ptw_mem #(
      .MEM_WORDS (MEM_WORDS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output slot can take a result this cycle
   assign out_free = ~out_valid_ff | ~rsp_stall;

   // items are taken only between walks and after the clearing sweep
   assign req_stall = (state_ff != ptw_pkg::ST_IDLE);

   assign widx_ext = EAW'(req_word_index);
   assign pte      = mem_rd_data;
   assign lvl_next = lvl_ff - 2'd1;

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      lvl_in      = lvl_ff;
      va_in       = va_ff;
      oor_in      = oor_ff;
      ent2_in     = ent2_ff;
      ent1_in     = ent1_ff;
      ent0_in     = ent0_ff;
      vmask_in    = vmask_ff;
      ok_in       = ok_ff;
      fault_in    = fault_ff;
      leaf_lvl_in = leaf_lvl_ff;
      leaf_in     = leaf_ff;
      pa_in       = pa_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = widx_ext[AW-1:0];
      mem_wr_data = req_word_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      ent_addr    = '0;
      walk_done   = 1'b0;
      load_out    = 1'b0;

      unique case (state_ff)
         ptw_pkg::ST_CLEAR: begin
            // zero sweep after reset
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == ClrLast) begin
               state_in = ptw_pkg::ST_IDLE;
            end
         end

         ptw_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == ptw_pkg::REQ_WRITE) begin
                  // out-of-range writes are dropped
                  mem_wr_en = (widx_ext < MemLimit);
               end else begin
                  // start at the root table, issue the level-2 read now
                  ent_addr    = {root_ppn, ptw_pkg::vpn_sel(req_vaddr, ptw_pkg::LVL_TOP)};
                  oor_in      = (ent_addr >= MemLimit);
                  mem_rd_en   = ~oor_in;
                  mem_rd_addr = ent_addr[AW-1:0];
                  lvl_in      = ptw_pkg::LVL_TOP;
                  va_in       = req_vaddr;
                  ent2_in     = '0;
                  ent1_in     = '0;
                  ent0_in     = '0;
                  vmask_in    = '0;
                  ok_in       = 1'b0;
                  fault_in    = ptw_pkg::FAULT_NONE;
                  leaf_lvl_in = '0;
                  leaf_in     = '0;
                  pa_in       = '0;
                  state_in    = ptw_pkg::ST_WALK;
               end
            end
         end

         ptw_pkg::ST_WALK: begin
            if (oor_ff) begin
               // nothing was read at this level
               fault_in  = ptw_pkg::FAULT_RANGE;
               walk_done = 1'b1;
            end else begin
               case (lvl_ff)
                  ptw_pkg::LVL_TOP: ent2_in = pte;
                  ptw_pkg::LVL_MID: ent1_in = pte;
                  default:          ent0_in = pte;
               endcase
               if (!pte[0]) begin
                  fault_in  = ptw_pkg::FAULT_INVALID;
                  walk_done = 1'b1;
               end else begin
                  vmask_in = vmask_ff | (3'b001 << lvl_ff);
                  if (pte[3:1] != 3'b000) begin
                     // leaf, any of r/w/x
                     ok_in       = 1'b1;
                     fault_in    = ptw_pkg::FAULT_NONE;
                     leaf_lvl_in = lvl_ff;
                     leaf_in     = pte;
                     pa_in       = ptw_pkg::pa_build(pte, va_ff, lvl_ff);
                     walk_done   = 1'b1;
                  end else if (lvl_ff == ptw_pkg::LVL_BOT) begin
                     fault_in  = ptw_pkg::FAULT_NO_LEAF;
                     walk_done = 1'b1;
                  end else begin
                     // pointer: next table read goes out right away
                     ent_addr    = {pte[ptw_pkg::PTE_SHIFT +: ptw_pkg::PPN_W],
                                    ptw_pkg::vpn_sel(va_ff, lvl_next)};
                     oor_in      = (ent_addr >= MemLimit);
                     mem_rd_en   = ~oor_in;
                     mem_rd_addr = ent_addr[AW-1:0];
                     lvl_in      = lvl_next;
                  end
               end
            end
            if (walk_done) begin
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = ptw_pkg::ST_IDLE;
               end else begin
                  state_in = ptw_pkg::ST_HOLD;
               end
            end
         end

         ptw_pkg::ST_HOLD: begin
            // finished result waits for the output slot
            if (out_free) begin
               load_out = 1'b1;
               state_in = ptw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ptw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptw_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // walk working registers
   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      va_ff       <= va_in;
      oor_ff      <= oor_in;
      ent2_ff     <= ent2_in;
      ent1_ff     <= ent1_in;
      ent0_ff     <= ent0_in;
      vmask_ff    <= vmask_in;
      ok_ff       <= ok_in;
      fault_ff    <= fault_in;
      leaf_lvl_ff <= leaf_lvl_in;
      leaf_ff     <= leaf_in;
      pa_ff       <= pa_in;
   end

   // output payload, loaded from the finished walk
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ok_ff       <= ok_in;
         out_fault_ff    <= fault_in;
         out_leaf_lvl_ff <= leaf_lvl_in;
         out_leaf_ff     <= leaf_in;
         out_pa_ff       <= pa_in;
         out_ent2_ff     <= ent2_in;
         out_ent1_ff     <= ent1_in;
         out_ent0_ff     <= ent0_in;
         out_vmask_ff    <= vmask_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_walk_ok          = out_ok_ff;
   assign rsp_fault_code       = out_fault_ff;
   assign rsp_page_level       = out_leaf_lvl_ff;
   assign rsp_leaf_entry       = out_leaf_ff;
   assign rsp_phys_addr        = out_pa_ff;
   assign rsp_entry_level2     = out_ent2_ff;
   assign rsp_entry_level1     = out_ent1_ff;
   assign rsp_entry_level0     = out_ent0_ff;
   assign rsp_level_valid_mask = out_vmask_ff;

endmodule

// ===== tb/ptw_walk_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptw_walk_checker
// passive checker of the sv39 page table walker: it follows the csr port and
// the request channel, keeps its own page-table memory and root page number,
// works out every walk result and compares it with the response channel
// ----------------------------------------------------------------------------
module ptw_walk_checker
   import ptw_pkg::*;
#(
   parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                    csr_pready,

   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_type,
   input  logic [VA_W-1:0]         req_vaddr,
   input  logic [11:0]             req_word_index,
   input  logic [PTE_W-1:0]        req_word_data,

   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_walk_ok,
   input  logic [1:0]              rsp_fault_code,
   input  logic [1:0]              rsp_page_level,
   input  logic [PTE_W-1:0]        rsp_leaf_entry,
   input  logic [PA_W-1:0]         rsp_phys_addr,
   input  logic [PTE_W-1:0]        rsp_entry_level2,
   input  logic [PTE_W-1:0]        rsp_entry_level1,
   input  logic [PTE_W-1:0]        rsp_entry_level0,
   input  logic [2:0]              rsp_level_valid_mask,

   output int                      results_pending,
   output int                      mismatch_count
);

   typedef struct packed {
      logic             walk_ok;
      logic [1:0]       fault_code;
      logic [1:0]       page_level;
      logic [PTE_W-1:0] leaf_entry;
      logic [PA_W-1:0]  phys_addr;
      logic [PTE_W-1:0] entry_level2;
      logic [PTE_W-1:0] entry_level1;
      logic [PTE_W-1:0] entry_level0;
      logic [2:0]       level_valid_mask;
   } walk_result_type;

   logic [PTE_W-1:0] table_mem [MEM_WORDS];
   logic [PPN_W-1:0] root_page;
   walk_result_type  expected_walks [$];
   int               err_cnt;

   // three-level walk over the local copy of the page-table memory
   function automatic walk_result_type predict_walk(input logic [VA_W-1:0] va);
      walk_result_type  r;
      logic [63:0]      page;
      logic [63:0]      addr;
      logic [PTE_W-1:0] pte;
      logic [PA_W-1:0]  pmask;
      int               lvl;
      bit               done;
      r    = '0;
      page = 64'(root_page);
      done = 1'b0;
      for (lvl = 2; lvl >= 0; lvl--) begin
         if (!done) begin
            addr = (page << LVL_BITS)
                 + ((64'(va) >> (PG_SHIFT + lvl * LVL_BITS)) & 64'h1FF);
            if (addr >= 64'(MEM_WORDS)) begin
               // entry address outside the memory, nothing read here
               r.fault_code = FAULT_RANGE;
               done = 1'b1;
            end else begin
               pte = table_mem[addr];
               case (2'(lvl))
                  LVL_TOP: r.entry_level2 = pte;
                  LVL_MID: r.entry_level1 = pte;
                  default: r.entry_level0 = pte;
               endcase
               if (!pte[0]) begin
                  r.fault_code = FAULT_INVALID;
                  done = 1'b1;
               end else begin
                  r.level_valid_mask[lvl] = 1'b1;
                  if (pte[3:1] != 3'b000) begin
                     // leaf, superpage ppn low bits replaced by the offset
                     pmask = (PA_W'(1) << (PG_SHIFT + lvl * LVL_BITS)) - PA_W'(1);
                     r.walk_ok    = 1'b1;
                     r.fault_code = FAULT_NONE;
                     r.page_level = 2'(lvl);
                     r.leaf_entry = pte;
                     r.phys_addr  = ({pte[PTE_SHIFT +: PPN_W], 12'd0} & ~pmask)
                                  | (PA_W'(va) & pmask);
                     done = 1'b1;
                  end else if (lvl == 0) begin
                     r.fault_code = FAULT_NO_LEAF;
                     done = 1'b1;
                  end else begin
                     page = 64'(pte[PTE_SHIFT +: PPN_W]);
                  end
               end
            end
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin : monitor
      walk_result_type want;
      if (reset) begin
         for (int i = 0; i < MEM_WORDS; i++) table_mem[i] = '0;
         root_page = '0;
         expected_walks.delete();
         err_cnt = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_idx_type'(csr_paddr[3]) == CSR_ROOT_PPN)
               root_page = csr_pwdata[PPN_W-1:0];
         end

         // responses first: a walk taken at this edge cannot answer yet
         if (rsp_valid && !rsp_stall) begin
            if (expected_walks.size() == 0) begin
               $display("%0t: result with no walk pending, expected none, actual %h",
                        $time, rsp_phys_addr);
               err_cnt++;
            end else begin
               want = expected_walks.pop_front();
               check_field("walk_ok", 64'(want.walk_ok), 64'(rsp_walk_ok));
               check_field("fault_code", 64'(want.fault_code), 64'(rsp_fault_code));
               check_field("page_level", 64'(want.page_level), 64'(rsp_page_level));
               check_field("leaf_entry", want.leaf_entry, rsp_leaf_entry);
               check_field("phys_addr", 64'(want.phys_addr), 64'(rsp_phys_addr));
               check_field("entry_level2", want.entry_level2, rsp_entry_level2);
               check_field("entry_level1", want.entry_level1, rsp_entry_level1);
               check_field("entry_level0", want.entry_level0, rsp_entry_level0);
               check_field("level_valid_mask", 64'(want.level_valid_mask),
                           64'(rsp_level_valid_mask));
            end
         end

         if (req_valid && !req_stall) begin
            if (req_kind_type'(req_type) == REQ_WALK)
               expected_walks.push_back(predict_walk(req_vaddr));
            else if (64'(req_word_index) < 64'(MEM_WORDS))
               table_mem[req_word_index] = req_word_data;
         end
      end
      results_pending <= expected_walks.size();
      mismatch_count  <= err_cnt;
   end

endmodule

// ===== tb/tb_sv39_page_table_walker_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sv39_page_table_walker_unit
// stimulus and verdict for the sv39 page table walker: directed page trees
// for every walk outcome, then random writes and walks over a few hot table
// slots under several root page numbers, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_sv39_page_table_walker_unit;
   import ptw_pkg::*;

   // csr byte addresses, the register index sits at bit 3
   localparam logic [CSR_ADDR_W-1:0] ADDR_ROOT_PPN = {CSR_ROOT_PPN, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED   = {CSR_UNUSED, 3'b000};

   // low ten pte bits for the directed trees
   localparam logic [9:0] FLAGS_PTR    = 10'h001;   // valid pointer
   localparam logic [9:0] FLAGS_READ   = 10'h003;   // readable leaf
   localparam logic [9:0] FLAGS_W_ONLY = 10'h005;   // reserved w without r

   localparam int IDLE_GAP         = 8;        // cycles past the last result
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LIMIT_NS         = 8_000_000;

   logic                    clock = 1'b0;
   logic                    reset;

   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   logic                    req_valid;
   logic                    req_stall;
   logic                    req_type;
   logic [VA_W-1:0]         req_vaddr;
   logic [11:0]             req_word_index;
   logic [PTE_W-1:0]        req_word_data;

   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_walk_ok;
   logic [1:0]              rsp_fault_code;
   logic [1:0]              rsp_page_level;
   logic [PTE_W-1:0]        rsp_leaf_entry;
   logic [PA_W-1:0]         rsp_phys_addr;
   logic [PTE_W-1:0]        rsp_entry_level2;
   logic [PTE_W-1:0]        rsp_entry_level1;
   logic [PTE_W-1:0]        rsp_entry_level0;
   logic [2:0]              rsp_level_valid_mask;

   int                      results_pending;
   int                      mismatch_count;

   // shared between the sender and the receiver
   bit                      calm      = 1'b0;   // no idling at all
   bit                      long_hold = 1'b0;   // receiver backs up the walker

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sv39_page_table_walker_unit dut (
      .clock                (clock),
      .reset                (reset),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_vaddr            (req_vaddr),
      .req_word_index       (req_word_index),
      .req_word_data        (req_word_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_walk_ok          (rsp_walk_ok),
      .rsp_fault_code       (rsp_fault_code),
      .rsp_page_level       (rsp_page_level),
      .rsp_leaf_entry       (rsp_leaf_entry),
      .rsp_phys_addr        (rsp_phys_addr),
      .rsp_entry_level2     (rsp_entry_level2),
      .rsp_entry_level1     (rsp_entry_level1),
      .rsp_entry_level0     (rsp_entry_level0),
      .rsp_level_valid_mask (rsp_level_valid_mask)
   );

   ptw_walk_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_pready           (csr_pready),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_vaddr            (req_vaddr),
      .req_word_index       (req_word_index),
      .req_word_data        (req_word_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_walk_ok          (rsp_walk_ok),
      .rsp_fault_code       (rsp_fault_code),
      .rsp_page_level       (rsp_page_level),
      .rsp_leaf_entry       (rsp_leaf_entry),
      .rsp_phys_addr        (rsp_phys_addr),
      .rsp_entry_level2     (rsp_entry_level2),
      .rsp_entry_level1     (rsp_entry_level1),
      .rsp_entry_level0     (rsp_entry_level0),
      .rsp_level_valid_mask (rsp_level_valid_mask),
      .results_pending      (results_pending),
      .mismatch_count       (mismatch_count)
   );

   // setup phase, then access phase until pready, then back to idle
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // offer one item, maybe after an idle burst, and wait until it is taken
   task automatic send_item(input req_kind_type kind, input logic [VA_W-1:0] va,
                            input logic [11:0] idx, input logic [PTE_W-1:0] data);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_vaddr      <= va;
      req_word_index <= idx;
      req_word_data  <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // the fields a walk or a write ignores still carry random bits
   task automatic walk(input logic [VA_W-1:0] va);
      send_item(REQ_WALK, va, 12'($urandom), {$urandom, $urandom});
   endtask

   task automatic store(input logic [11:0] idx, input logic [PTE_W-1:0] data);
      send_item(REQ_WRITE, VA_W'({$urandom, $urandom}), idx, data);
   endtask

   // stop offering, let every walk come back, then let a trailing write settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      // the pending count is a registered copy of the checker queue size, so it lags
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   // a few vpn values per table, so random writes build deep trees
   function automatic logic [8:0] hot_vpn();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0) return 9'($urandom);
      return (pick < 4) ? 9'(pick) : 9'(504 + pick);
   endfunction

   // mostly pointers back into the memory, then leaves, invalid entries and
   // pointers to arbitrary pages; upper and flag bits stay random
   function automatic logic [PTE_W-1:0] make_pte();
      logic [PTE_W-1:0] pte;
      int unsigned      pick;
      pte  = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         pte[3:0]               = 4'b0001;
         pte[PTE_SHIFT +: PPN_W] = PPN_W'($urandom_range(0, 7));
      end else if (pick < 8) begin
         pte[0] = 1'b1;
         if (pte[3:1] == 3'b000) pte[3:1] = 3'($urandom_range(1, 7));
      end else if (pick == 8) begin
         pte[0] = 1'b0;
      end else begin
         pte[3:0] = 4'b0001;
      end
      return pte;
   endfunction

   task automatic random_item();
      if ($urandom_range(0, 99) < 55) begin
         if ($urandom_range(0, 9) < 8)
            walk({hot_vpn(), hot_vpn(), hot_vpn(), 12'($urandom)});
         else
            walk(VA_W'({$urandom, $urandom}));
      end else begin
         if ($urandom_range(0, 9) < 8)
            store({3'($urandom_range(0, 7)), hot_vpn()}, make_pte());
         else
            store(12'($urandom), {$urandom, $urandom});
      end
   endtask

   // one setting of the root page, random upper csr bits must be dropped
   task automatic run_phase(input logic [PPN_W-1:0] root, input int count);
      wait_idle();
      csr_write(ADDR_ROOT_PPN, {20'($urandom), root});
      if ($urandom_range(0, 1) == 1) csr_write(ADDR_UNUSED, {$urandom, $urandom});
      repeat (count) random_item();
      wait_idle();
   endtask

   // receiver: random stall bursts, free stretches and one long hold-off
   initial begin : rsp_side
      int unsigned len;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            // results pile up, the walker fills and stalls its input
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            repeat (len - 1) @(posedge clock);
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            len = $urandom_range(20, 80);
            rsp_stall <= 1'b0;
            repeat (len - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      reset          <= 1'b1;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      req_valid      <= 1'b0;
      req_type       <= REQ_WRITE;
      req_vaddr      <= '0;
      req_word_index <= '0;
      req_word_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // the memory clear pass after reset holds req_stall, csr writes are fine
      csr_write(ADDR_ROOT_PPN, '0);
      csr_write(ADDR_UNUSED, {$urandom, $urandom});

      // ---- directed trees under root page 0 ----
      // empty memory: invalid at the top level, both ends of the address range
      walk('0);
      walk('1);
      // all-ones word as a 1 GiB leaf, unaligned ppn bits get the offset
      store(12'h1FF, '1);
      walk('1);
      // root slot 0 -> page 1 -> page 2
      store(12'd0, {10'd0, 44'd1, FLAGS_PTR});
      store(12'd512, {10'd0, 44'd2, FLAGS_PTR});
      // reserved write-only permission taken as a 4 KiB leaf
      store(12'd1024 + 12'd5, {10'h3FF, 44'h00ABCDE, FLAGS_W_ONLY});
      walk({9'd0, 9'd0, 9'd5, 12'hFFF});
      // pointer still found at the bottom level
      store(12'd1024 + 12'd6, {10'd0, 44'd1, FLAGS_PTR});
      walk({9'd0, 9'd0, 9'd6, 12'h000});
      // 2 MiB leaf with low ppn bits set
      store(12'd513, {10'd0, 44'h123_4567_89AB, FLAGS_READ});
      walk({9'd0, 9'd1, 9'h1AB, 12'h5A5});
      // pointer to the highest page, out of range at the bottom level
      store(12'd514, {10'd0, {PPN_W{1'b1}}, FLAGS_PTR});
      walk({9'd0, 9'd2, 9'h1FF, 12'h000});
      // invalid entry with every other bit set, still reported as read
      store(12'd1024 + 12'd7, 64'hFFFF_FFFF_FFFF_FFFE);
      walk({9'd0, 9'd0, 9'd7, 12'h001});
      // pointer to page 8, one past the memory, fails at the middle level
      store(12'd1, {10'd0, 44'd8, FLAGS_PTR});
      walk({9'd1, 9'd0, 9'd0, 12'h000});
      // top word of the memory
      store(12'hFFF, '1);

      // ---- random phases over several root pages ----
      run_phase('0, 500);
      long_hold = 1'b1;
      run_phase(44'd7, 300);
      run_phase({PPN_W{1'b1}}, 40);   // every walk out of range at the top
      run_phase(44'd8, 40);           // just past the memory
      run_phase(44'd3, 300);
      run_phase(44'd1, 300);
      calm = 1'b1;
      run_phase(PPN_W'($urandom_range(0, 7)), 300);

      if (mismatch_count == 0 && results_pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
